>>> sv/slir_pkg.sv
// ----------------------------------------------------------------------------
// slir_pkg: shared types and constants of the sorted list.
// Holds the entry width, the result count width, the action codes and the
// command word that the list control broadcasts to every cell.
// ----------------------------------------------------------------------------
package slir_pkg;

  // Width of one held entry and of the reported count.
  localparam int DataW  = 32;
  localparam int CountW = 4;

  // Action codes of an input beat.
  localparam logic ActInsert = 1'b0;
  localparam logic ActRemove = 1'b1;

  typedef logic signed [DataW-1:0] data_t;

  // Command broadcast to all cells for one accepted beat.
  typedef struct packed {
    logic  ins;    // insert that succeeds (list not full)
    logic  rem;    // remove that succeeds (value present)
    data_t value;  // operand of the beat
  } cell_cmd_t;

endpackage

>>> sv/slir_in_if.sv
// ----------------------------------------------------------------------------
// slir_in_if: request channel of the sorted list.
// Carries the action and the operand value under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface slir_in_if
  import slir_pkg::*;
();

  logic  valid;
  logic  ready;
  logic  action;
  data_t value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);

endinterface

>>> sv/slir_out_if.sv
// ----------------------------------------------------------------------------
// slir_out_if: result channel of the sorted list.
// Carries the status of one operation under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface slir_out_if
  import slir_pkg::*;
();

  logic              valid;
  logic              ready;
  logic              ok;
  logic [CountW-1:0] count;
  data_t             smallest;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, output ok, output count, output smallest,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input count, input smallest,
                  input is_empty, input is_full, output ready);

endinterface

>>> sv/slir_cell.sv
// ----------------------------------------------------------------------------
// slir_cell: one position of the sorted list.
// Holds one entry, compares it with the broadcast operand and, on an insert
// or remove, takes the operand or a neighbor's entry so the row stays sorted.
// ----------------------------------------------------------------------------
module slir_cell
  import slir_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      valid_i,     // this position holds an entry
  input  logic      left_le_i,   // every entry to the left is <= operand
  input  data_t     left_val_i,  // entry of the left neighbor
  input  data_t     right_val_i, // entry of the right neighbor
  output logic      le_o,        // this entry and all to the left are <= operand
  output logic      eq_o,        // this entry equals the operand
  output data_t     value_o
);

  data_t value_q, value_d;
  logic  lt;

  // Compare against the broadcast operand; invalid positions never match.
  assign le_o = valid_i && (value_q <= cmd_i.value);
  assign lt   = valid_i && (value_q < cmd_i.value);
  assign eq_o = valid_i && (value_q == cmd_i.value);

  // Insert: positions past the slot shift right, the slot takes the operand.
  // Remove: the matching entry and all after it shift left.
  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (le_o) begin
        value_d = value_q;
      end else if (left_le_i) begin
        value_d = cmd_i.value;
      end else begin
        value_d = left_val_i;
      end
    end else if (cmd_i.rem && !lt) begin
      value_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> sv/sorted_list_insert_remove.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: bounded ascending list of signed 32-bit values.
//
// Each request beat on req_i carries an action (insert or remove) and a
// value. An insert places the value after every equal or smaller entry and
// fails on a full list. A remove deletes the first equal entry and fails on
// an empty list or an absent value. Every request yields exactly one result
// beat on rsp_o with the success flag, the count after the operation, the
// smallest entry (0 when empty) and empty and full flags.
// The list is a row of CAPACITY cells that all compare against the operand
// and shift toward or away from the slot in the same clock edge, so the list
// updates at the edge that accepts the request. The result is valid in the
// cycle after acceptance; one request is taken per cycle while results drain.
// When rsp_o stalls, the result holds and req_i is not ready until the
// result is taken. Reset empties the list and drops any pending result; the
// cell contents are not cleared, since only held positions are ever read.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove
  import slir_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  slir_in_if.sink    req_i,
  slir_out_if.source rsp_o
);

  localparam int FillW = $clog2(CAPACITY + 1);

  logic [FillW-1:0] fill_q, fill_d;
  logic             rsp_valid_q;
  logic             ok_q;

  logic             accept;
  logic             full, empty, found;
  logic             ins_ok, rem_ok;
  cell_cmd_t        cmd;

  data_t            cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_le;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_valid;

  // Handshake: a new request enters when the result register is free or drains.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full  = (fill_q == FillW'(CAPACITY));
  assign empty = (fill_q == '0);
  assign found = |cell_eq;

  assign ins_ok = accept && (req_i.action == ActInsert) && !full;
  assign rem_ok = accept && (req_i.action == ActRemove) && found;

  assign cmd.ins   = ins_ok;
  assign cmd.rem   = rem_ok;
  assign cmd.value = req_i.value;

  // Row of cells; each sees its neighbors' entries and the left compare flag.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  left_le;
    data_t left_val;
    data_t right_val;

    assign cell_valid[i] = (fill_q > FillW'(i));

    if (i == 0) begin : g_first
      assign left_le  = 1'b1;
      assign left_val = cell_val[i];
    end else begin : g_mid
      assign left_le  = cell_le[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    slir_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (cell_valid[i]),
      .left_le_i   (left_le),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .le_o        (cell_le[i]),
      .eq_o        (cell_eq[i]),
      .value_o     (cell_val[i])
    );
  end

  // Fill count follows the successful operations.
  always_comb begin
    fill_d = fill_q;
    if (ins_ok) begin
      fill_d = fill_q + FillW'(1);
    end else if (rem_ok) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Success flag of the last accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q <= ins_ok || rem_ok;
    end
  end

  // The list only changes on acceptance, so the status reads the live state.
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.ok       = ok_q;
  assign rsp_o.count    = CountW'(fill_q);
  assign rsp_o.smallest = empty ? '0 : cell_val[0];
  assign rsp_o.is_empty = empty;
  assign rsp_o.is_full  = full;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_ok |=> fill_q == $past(fill_q) + FillW'(1))
    else $error("successful insert did not grow the list");

  a_fail_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ins_ok && !rem_ok) |=> $stable(fill_q))
    else $error("failed operation changed the fill count");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q && (ok_q == $past(ins_ok || rem_ok)))
    else $error("result beat missing after an accepted request");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q >= FillW'(2)) |-> (cell_val[0] <= cell_val[1]))
    else $error("list head out of order");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the sorted list.
// Drives insert and remove beats into the list, keeps a bounded ascending
// list of its own to work out the status of every operation, and compares
// each result beat field by field with the oldest outstanding expectation.
// Both sides idle in random bursts, and the result side holds off once long
// enough for the list to stall its request side.
// ----------------------------------------------------------------------------
module tb_top;
  import slir_pkg::*;

  localparam int Cap       = 8;
  localparam int RandItems = 1630;
  localparam int QuietTail = 200;

  // Status of the list after one operation, as carried by a result beat.
  typedef struct packed {
    logic              ok;
    logic [CountW-1:0] count;
    data_t             smallest;
    logic              is_empty;
    logic              is_full;
  } list_status_t;

  // Scoreboard: a sorted list of its own plus the queue of statuses that
  // the block still owes.
  class list_scoreboard;
    data_t        held[Cap];
    int           fill;
    list_status_t status_q[$];
    int           errors;
    int           n_insert;
    int           n_remove;
    int           n_rejected;
    int           n_full;
    int           n_empty;
    int           n_checked;

    function new();
      fill       = 0;
      errors     = 0;
      n_insert   = 0;
      n_remove   = 0;
      n_rejected = 0;
      n_full     = 0;
      n_empty    = 0;
      n_checked  = 0;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // Picks one of the values held at the moment; the list must not be empty.
    function data_t pick_held();
      return held[$urandom_range(fill - 1)];
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Applies an accepted request to the list and queues the status it yields.
    function void note_request(logic act, data_t val);
      list_status_t st;
      int           pos;
      logic         ok;
      ok  = 1'b0;
      pos = 0;
      if (act == ActInsert) begin
        n_insert++;
        // Equal values go after the ones already held.
        if (fill < Cap) begin
          while (pos < fill && held[pos] <= val) pos++;
          for (int i = fill; i > pos; i--) held[i] = held[i-1];
          held[pos] = val;
          fill++;
          ok = 1'b1;
        end
      end else begin
        n_remove++;
        // Only the first equal entry leaves the list.
        if (fill > 0) begin
          while (pos < fill && held[pos] < val) pos++;
          if (pos < fill && held[pos] == val) begin
            for (int i = pos + 1; i < fill; i++) held[i-1] = held[i];
            fill--;
            ok = 1'b1;
          end
        end
      end
      if (!ok) n_rejected++;
      if (fill == Cap) n_full++;
      if (fill == 0) n_empty++;
      st.ok       = ok;
      st.count    = CountW'(fill);
      st.smallest = (fill > 0) ? held[0] : '0;
      st.is_empty = (fill == 0);
      st.is_full  = (fill == Cap);
      status_q.push_back(st);
    endfunction

    // Compares one result beat with the oldest expectation.
    task check_result(list_status_t got);
      list_status_t want;
      if (status_q.size() == 0) begin
        report("result beat with no request outstanding");
      end else begin
        want = status_q.pop_front();
        n_checked++;
        if (got.ok !== want.ok)
          report($sformatf("ok got %b want %b", got.ok, want.ok));
        if (got.count !== want.count)
          report($sformatf("count got %0d want %0d", got.count, want.count));
        if (got.smallest !== want.smallest)
          report($sformatf("smallest got %0d want %0d", got.smallest, want.smallest));
        if (got.is_empty !== want.is_empty)
          report($sformatf("is_empty got %b want %b", got.is_empty, want.is_empty));
        if (got.is_full !== want.is_full)
          report($sformatf("is_full got %b want %b", got.is_full, want.is_full));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  slir_in_if  req_if ();
  slir_out_if rsp_if ();

  list_scoreboard sb = new();

  // Idling control: the quiet flag is shared by both sides, the idle share is the request side's.
  bit quiet;
  int tx_idle_pct;

  sorted_list_insert_remove #(
    .CAPACITY(Cap)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Clock with a 12 ns period.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Overall limit of the run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Offers one request beat, after an optional idle burst, and waits for it
  // to be taken.
  task automatic send_beat(logic act, data_t val);
    int gap;
    if (!quiet && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 5);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.value  <= val;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(act, val);
  endtask

  // Directed part: empty and full lists, absent values, duplicates and the
  // extremes of the value range.
  task automatic run_directed();
    send_beat(ActRemove, 32'sd5);
    send_beat(ActInsert, 32'sh7FFF_FFFF);
    send_beat(ActInsert, 32'sh8000_0000);
    send_beat(ActInsert, 32'sd0);
    send_beat(ActInsert, -32'sd1);
    send_beat(ActInsert, 32'sd5);
    send_beat(ActInsert, 32'sd5);
    send_beat(ActInsert, 32'sd1);
    send_beat(ActInsert, 32'sd2);
    send_beat(ActInsert, 32'sd3);
    send_beat(ActRemove, 32'sd7);
    send_beat(ActRemove, 32'sd5);
    send_beat(ActRemove, 32'sh8000_0000);
    send_beat(ActRemove, 32'sh7FFF_FFFF);
    send_beat(ActRemove, -32'sd1);
    send_beat(ActRemove, 32'sd0);
    send_beat(ActRemove, 32'sd1);
    send_beat(ActRemove, 32'sd2);
    send_beat(ActRemove, 32'sd5);
    send_beat(ActRemove, 32'sd0);
    send_beat(ActInsert, 32'sh5555_AAAA);
    send_beat(ActRemove, 32'sh5555_AAAA);
  endtask

  // Random part: the insert share drifts up and down so that the list keeps
  // swinging between empty and full, and most removes name a held value.
  task automatic run_random(int n);
    data_t pool[8];
    bit    grow;
    logic  act;
    data_t val;
    int    pick;
    pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1,
             32'sd1, 32'sd7, -32'sd7, 32'sd100};
    grow = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) grow = $urandom_range(1);
      if (i % 64 == 0) begin
        case ($urandom_range(2))
          0: tx_idle_pct = 0;
          1: tx_idle_pct = 20;
          default: tx_idle_pct = 50;
        endcase
      end
      quiet = (i >= n - QuietTail);
      act  = ($urandom_range(99) < (grow ? 75 : 25)) ? ActInsert : ActRemove;
      pick = $urandom_range(99);
      if (act == ActRemove && pick < 55 && sb.fill > 0) val = sb.pick_held();
      else if (pick < 75) val = pool[$urandom_range(7)];
      else val = data_t'($urandom);
      send_beat(act, val);
    end
  endtask

  // Result side: checks every beat taken and idles in random bursts, with
  // one long hold-off once sixty requests have gone in.
  initial begin
    list_status_t got;
    int           stall_left;
    int           rx_idle_pct;
    int           cycle;
    bit           hold_done;
    stall_left  = 0;
    rx_idle_pct = 0;
    cycle       = 0;
    hold_done   = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.ok       = rsp_if.ok;
        got.count    = rsp_if.count;
        got.smallest = rsp_if.smallest;
        got.is_empty = rsp_if.is_empty;
        got.is_full  = rsp_if.is_full;
        sb.check_result(got);
      end
      cycle++;
      if (cycle % 150 == 0) begin
        case ($urandom_range(2))
          0: rx_idle_pct = 0;
          1: rx_idle_pct = 20;
          default: rx_idle_pct = 50;
        endcase
      end
      if (!hold_done && sb.n_insert + sb.n_remove >= 60) begin
        hold_done  = 1'b1;
        stall_left = 48;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < rx_idle_pct) begin
        stall_left = $urandom_range(1, 5) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Reset, stimulus, drain and verdict.
  initial begin
    quiet       = 1'b0;
    tx_idle_pct = 30;
    rst_ni        <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.action <= ActInsert;
    req_if.value  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(RandItems);
    req_if.valid <= 1'b0;

    // Wait for every owed result, then idle on so that stray beats would show.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d requests (%0d inserts, %0d removes), %0d of them rejected.",
             sb.n_insert + sb.n_remove, sb.n_insert, sb.n_remove, sb.n_rejected);
    $display("Checked %0d results; the list stood full %0d times and empty %0d times.",
             sb.n_checked, sb.n_full, sb.n_empty);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/slir_pkg.sv
sv/slir_in_if.sv
sv/slir_out_if.sv
sv/slir_cell.sv
sv/sorted_list_insert_remove.sv
tb/sv/tb_top.sv
